### hw/rtl/crcfcg_pkg.sv
`timescale 1ns / 1ps
package crcfcg_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W = 6;
	localparam int IDX_LIM = (MAX_FRAME_BYTES - 1 > 63) ? 63 : MAX_FRAME_BYTES - 1;
	localparam int LEN_W = 7;
	localparam int CMP_W = ((COUNT_W > LEN_W) ? COUNT_W : LEN_W) + 1;
	localparam int CRC_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECV_LEN = 2'd3;

	localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
	localparam logic [CRC_W-1:0] INIT_RESET = 16'hFFFF;
	localparam logic [LEN_W-1:0] SEND_LEN_RESET = 7'd43;
	localparam logic [LEN_W-1:0] RECV_LEN_RESET = 7'd29;

	localparam logic [7:0] HDR_FIRST = 8'h53;
	localparam logic [7:0] HDR_SECOND = 8'h50;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_HDR = 2'd2;
	localparam logic [1:0] ST_BAD_CRC = 2'd3;

	localparam logic [1:0] JOB_ECHO = 2'd0;
	localparam logic [1:0] JOB_CHECK = 2'd1;
	localparam logic [1:0] JOB_GEN = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [IDX_W-1:0] byte_index;
		logic             is_appended;
		logic             frame_done;
		logic [1:0]       status;
		logic             last_result;
	} out_word_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic [1:0]       status;
		logic [CRC_W-1:0] crc;
	} job_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
			input logic [7:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[CRC_W-1]) begin
				r = {r[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[CRC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] sat_idx(input logic [CMP_W-1:0] pos);
		logic [IDX_W-1:0] res;
		if (pos > CMP_W'(IDX_LIM)) begin
			res = IDX_W'(IDX_LIM);
		end else begin
			res = pos[IDX_W-1:0];
		end
		return res;
	endfunction

endpackage

### hw/rtl/crc16_frame_checker_generator.sv
`timescale 1ns / 1ps
// Framed CRC-16 checker and generator. Frame bytes enter one word per cycle on in_*
// while the queue has room, the last one flagged by in_last; the CRC is MSB-first with
// the polynomial and seed taken from registers 0 and 1 (seed applied at each frame
// start), and registers 2 and 3 hold the expected send and receive frame lengths. In
// check modes every byte comes back with its index and the last one carries the status;
// in generate mode the body is echoed and the CRC low and high bytes follow. The front
// end updates the CRC and classifies each byte in the cycle it is accepted, so input
// runs at one byte per cycle while the queue has room; a two-entry job queue feeds the
// back end, which drives a registered output at one word per cycle unless out_ready
// stalls; a generate-mode last byte yields three output words. An accepted byte goes
// through the job queue and the output register. The cfg port is always ready.
module crc16_frame_checker_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [crcfcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crcfcg_pkg::CRC_W-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  crcfcg_pkg::in_word_t             in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output crcfcg_pkg::out_word_t            out_data
);
	import crcfcg_pkg::*;

	job_t  new_job;
	job_t  head_job;
	logic  q_not_full;
	logic  head_valid;
	logic  pop;
	logic  accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = q_not_full;
	assign accept    = in_valid && q_not_full;

	crcfcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_data   (in_data),
		.job       (new_job)
	);

	crcfcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (new_job),
		.not_full   (q_not_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	crcfcg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

### hw/rtl/crcfcg_front.sv
`timescale 1ns / 1ps
module crcfcg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [crcfcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crcfcg_pkg::CRC_W-1:0]     cfg_data,
	input  logic                           accept,
	input  crcfcg_pkg::in_word_t           in_data,
	output crcfcg_pkg::job_t               job
);
	import crcfcg_pkg::*;

	logic [CRC_W-1:0]   poly_q;
	logic [CRC_W-1:0]   init_q;
	logic [LEN_W-1:0]   send_len_q;
	logic [LEN_W-1:0]   recv_len_q;

	logic [CRC_W-1:0]   running_crc_q;
	logic [CRC_W-1:0]   one_back_q;
	logic [7:0]         prev_byte_q;
	logic [COUNT_W-1:0] count_q;
	logic               header_good_q;

	logic               start;
	logic [CRC_W-1:0]   base;
	logic [CRC_W-1:0]   two_back;
	logic [CRC_W-1:0]   crc_next;
	logic               hdr_next;
	logic [CMP_W-1:0]   pos;
	logic [CMP_W-1:0]   want;
	logic [1:0]         check_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q     <= POLY_RESET;
			init_q     <= INIT_RESET;
			send_len_q <= SEND_LEN_RESET;
			recv_len_q <= RECV_LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CRC_POLY: poly_q     <= cfg_data;
				REG_CRC_INIT: init_q     <= cfg_data;
				REG_SEND_LEN: send_len_q <= cfg_data[LEN_W-1:0];
				REG_RECV_LEN: recv_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero count marks frame start: seed from the current init value
	assign start    = (count_q == '0);
	assign base     = start ? init_q : running_crc_q;
	assign two_back = start ? init_q : one_back_q;
	assign crc_next = crc_byte(base, in_data.in_byte, poly_q);
	assign pos      = CMP_W'(count_q);
	assign want     = in_data.mode[0] ? CMP_W'(recv_len_q) : CMP_W'(send_len_q);

	always_comb begin
		hdr_next = start ? 1'b1 : header_good_q;
		if (start && in_data.in_byte != HDR_FIRST) begin
			hdr_next = 1'b0;
		end
		if (count_q == COUNT_W'(1) && in_data.in_byte != HDR_SECOND) begin
			hdr_next = 1'b0;
		end
	end

	always_comb begin
		if (want > CMP_W'(MAX_FRAME_BYTES) || pos >= CMP_W'(MAX_FRAME_BYTES) ||
				pos + CMP_W'(1) != want) begin
			check_status = ST_BAD_LEN;
		end else if (start || !hdr_next) begin
			check_status = ST_BAD_HDR;
		end else if (two_back != {in_data.in_byte, prev_byte_q}) begin
			check_status = ST_BAD_CRC;
		end else begin
			check_status = ST_OK;
		end
	end

	always_comb begin
		job.data   = in_data.in_byte;
		job.idx    = sat_idx(pos);
		job.crc    = crc_next;
		job.status = ST_OK;
		if (!in_data.in_last) begin
			job.kind = JOB_ECHO;
		end else if (in_data.mode[1]) begin
			job.kind = JOB_GEN;
		end else begin
			job.kind   = JOB_CHECK;
			job.status = check_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			header_good_q <= 1'b1;
		end else if (accept) begin
			header_good_q <= hdr_next;
			if (in_data.in_last) begin
				count_q <= '0;
			end else if (count_q < COUNT_W'(MAX_FRAME_BYTES)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			running_crc_q <= crc_next;
			one_back_q    <= base;
			prev_byte_q   <= in_data.in_byte;
		end
	end

endmodule

### hw/rtl/crcfcg_queue.sv
`timescale 1ns / 1ps
module crcfcg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  crcfcg_pkg::job_t push_job,
	output logic             not_full,
	input  logic             pop,
	output logic             head_valid,
	output crcfcg_pkg::job_t head_job
);
	import crcfcg_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t            mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign not_full   = (count_q < CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		logic [AW-1:0] n;
		if (p == AW'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + AW'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hw/rtl/crcfcg_back.sv
`timescale 1ns / 1ps
module crcfcg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  crcfcg_pkg::job_t      head_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output crcfcg_pkg::out_word_t out_data
);
	import crcfcg_pkg::*;

	localparam logic [1:0] PH_BODY   = 2'd0;
	localparam logic [1:0] PH_CRC_LO = 2'd1;
	localparam logic [1:0] PH_CRC_HI = 2'd2;

	logic [1:0]  phase_q;
	logic        out_valid_q;
	out_word_t   out_q;
	out_word_t   nxt;
	logic        load;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && (head_job.kind != JOB_GEN || phase_q == PH_CRC_HI);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		nxt.out_byte    = head_job.data;
		nxt.byte_index  = head_job.idx;
		nxt.is_appended = 1'b0;
		nxt.frame_done  = 1'b0;
		nxt.status      = ST_OK;
		nxt.last_result = 1'b1;
		case (head_job.kind)
			JOB_CHECK: begin
				nxt.frame_done = 1'b1;
				nxt.status     = head_job.status;
			end
			JOB_GEN: begin
				case (phase_q)
					PH_CRC_LO: begin
						nxt.out_byte    = head_job.crc[7:0];
						nxt.byte_index  = sat_idx(CMP_W'(head_job.idx) + CMP_W'(1));
						nxt.is_appended = 1'b1;
						nxt.last_result = 1'b0;
					end
					PH_CRC_HI: begin
						nxt.out_byte    = head_job.crc[15:8];
						nxt.byte_index  = sat_idx(CMP_W'(head_job.idx) + CMP_W'(2));
						nxt.is_appended = 1'b1;
						nxt.frame_done  = 1'b1;
					end
					default: begin
						nxt.last_result = 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BODY;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// advance through the three generate words, hold otherwise
			if (load && head_job.kind == JOB_GEN) begin
				case (phase_q)
					PH_BODY:   phase_q <= PH_CRC_LO;
					PH_CRC_LO: phase_q <= PH_CRC_HI;
					default:   phase_q <= PH_BODY;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

endmodule

### tb/crc16_frame_checker_generator_test.sv
`timescale 1ns / 1ps
import crcfcg_pkg::*;

localparam logic [1:0] MODE_SEND = 2'd0;
localparam logic [1:0] MODE_RECV = 2'd1;
localparam logic [1:0] MODE_GEN = 2'd2;
localparam logic [1:0] MODE_GEN_ALT = 2'd3;

typedef enum logic [1:0] {FLAW_NONE, FLAW_HEADER, FLAW_CRC, FLAW_LENGTH} frame_flaw_t;

function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b,
		input logic [15:0] poly);
	logic [15:0] r;
	r = c ^ {b, 8'h00};
	for (int k = 0; k < 8; k++) begin
		if (r[15]) begin
			r = {r[14:0], 1'b0} ^ poly;
		end else begin
			r = {r[14:0], 1'b0};
		end
	end
	return r;
endfunction

class frame_scoreboard;
	logic [15:0] poly;
	logic [15:0] crc_seed;
	logic [6:0]  send_len;
	logic [6:0]  recv_len;
	logic [15:0] crc_now;
	logic [15:0] crc_prev1;
	logic [15:0] crc_prev2;
	logic [7:0]  byte_before;
	int unsigned byte_pos;
	bit          header_ok;
	out_word_t   owed_words[$];
	int          errors;

	function new();
		poly = POLY_RESET;
		crc_seed = INIT_RESET;
		send_len = SEND_LEN_RESET;
		recv_len = RECV_LEN_RESET;
		errors = 0;
		restart();
	endfunction

	function void restart();
		crc_now = crc_seed;
		crc_prev1 = crc_seed;
		crc_prev2 = crc_seed;
		byte_before = 8'h00;
		byte_pos = 0;
		header_ok = 1'b1;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		case (idx)
			REG_CRC_POLY: poly = data;
			REG_CRC_INIT: crc_seed = data;
			REG_SEND_LEN: send_len = data[6:0];
			REG_RECV_LEN: recv_len = data[6:0];
			default: ;
		endcase
	endfunction

	function logic [IDX_W-1:0] clip_index(int unsigned pos);
		int unsigned lim;
		lim = (MAX_FRAME_BYTES - 1 > 63) ? 63 : MAX_FRAME_BYTES - 1;
		return IDX_W'((pos > lim) ? lim : pos);
	endfunction

	function void owe(logic [7:0] b, int unsigned pos, bit app, bit done, logic [1:0] st,
			bit tail);
		out_word_t w;
		w.out_byte = b;
		w.byte_index = clip_index(pos);
		w.is_appended = app;
		w.frame_done = done;
		w.status = st;
		w.last_result = tail;
		owed_words.push_back(w);
	endfunction

	function void take_byte(in_word_t w);
		int unsigned pos;
		int unsigned goal;
		logic [15:0] base;
		logic [1:0]  st;
		pos = byte_pos;
		base = (pos == 0) ? crc_seed : crc_now;
		if (pos == 0) begin
			crc_prev1 = crc_seed;
			header_ok = 1'b1;
		end
		crc_prev2 = crc_prev1;
		crc_prev1 = base;
		crc_now = crc16_byte(base, w.in_byte, poly);
		if ((pos == 0 && w.in_byte != HDR_FIRST) || (pos == 1 && w.in_byte != HDR_SECOND)) begin
			header_ok = 1'b0;
		end
		if (!w.in_last) begin
			byte_before = w.in_byte;
			if (byte_pos < MAX_FRAME_BYTES) begin
				byte_pos++;
			end
			owe(w.in_byte, pos, 1'b0, 1'b0, ST_OK, 1'b1);
			return;
		end
		if (w.mode[1]) begin
			owe(w.in_byte, pos, 1'b0, 1'b0, ST_OK, 1'b0);
			owe(crc_now[7:0], pos + 1, 1'b1, 1'b0, ST_OK, 1'b0);
			owe(crc_now[15:8], pos + 2, 1'b1, 1'b1, ST_OK, 1'b1);
			restart();
			return;
		end
		goal = (w.mode == MODE_SEND) ? send_len : recv_len;
		if (goal > MAX_FRAME_BYTES || pos >= MAX_FRAME_BYTES || pos + 1 != goal) begin
			st = ST_BAD_LEN;
		end else if (pos < 1 || !header_ok) begin
			st = ST_BAD_HDR;
		end else if (crc_prev2 != {w.in_byte, byte_before}) begin
			st = ST_BAD_CRC;
		end else begin
			st = ST_OK;
		end
		owe(w.in_byte, pos, 1'b0, 1'b1, st, 1'b1);
		restart();
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_word(out_word_t got);
		out_word_t want;
		if (owed_words.size() == 0) begin
			$display("%0t: output word with nothing owed, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = owed_words.pop_front();
		compare_field("out_byte", want.out_byte, got.out_byte);
		compare_field("byte_index", want.byte_index, got.byte_index);
		compare_field("is_appended", want.is_appended, got.is_appended);
		compare_field("frame_done", want.frame_done, got.frame_done);
		compare_field("status", want.status, got.status);
		compare_field("last_result", want.last_result, got.last_result);
	endfunction

	function int pending();
		return owed_words.size();
	endfunction
endclass

module crc16_frame_checker_generator_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_WORDS = 400;
	localparam int PHASE_WORDS = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CRC_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	frame_scoreboard board;
	bit no_gaps = 1'b0;
	int words_sent = 0;
	int stuck_cycles = 0;
	logic [15:0] cur_poly = POLY_RESET;
	logic [15:0] cur_seed = INIT_RESET;
	logic [6:0] cur_send = SEND_LEN_RESET;
	logic [6:0] cur_recv = RECV_LEN_RESET;

	crc16_frame_checker_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit take_break();
		return !no_gaps && ($urandom_range(99) < 26);
	endfunction

	always @(posedge clk) begin
		out_ready <= !take_break();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.write_reg(cfg_index, cfg_data);
			end
			if (out_valid && out_ready) begin
				board.check_word(out_data);
			end
			if (in_valid && in_ready) begin
				board.take_byte(in_data);
			end
			if ((cfg_valid && cfg_ready) || (out_valid && out_ready) || (in_valid && in_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// valid is left high on return so back-to-back words never toggle it
	task automatic drive_word(input in_word_t w);
		while (take_break()) begin
			in_valid <= 1'b0;
			in_data <= in_word_t'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	// length registers take only the low seven bits; fill the rest with junk
	task automatic configure(input logic [15:0] poly, input logic [15:0] seed,
			input logic [6:0] slen, input logic [6:0] rlen);
		write_reg(REG_CRC_POLY, poly);
		write_reg(REG_CRC_INIT, seed);
		write_reg(REG_SEND_LEN, {9'($urandom), slen});
		write_reg(REG_RECV_LEN, {9'($urandom), rlen});
		cfg_valid <= 1'b0;
		cur_poly = poly;
		cur_seed = seed;
		cur_send = slen;
		cur_recv = rlen;
	endtask

	// header, random body, little-endian CRC over all but the final two bytes
	task automatic send_frame(input logic [1:0] end_mode, input int len,
			input frame_flaw_t flaw, input bit mixed);
		logic [7:0] body[$];
		logic [15:0] crc;
		in_word_t w;
		int k;
		body = {};
		for (k = 0; k < len; k++) begin
			body.push_back(8'($urandom));
		end
		if (len > 0) begin
			body[0] = HDR_FIRST;
		end
		if (len > 1) begin
			body[1] = HDR_SECOND;
		end
		if (len >= 4) begin
			crc = cur_seed;
			for (k = 0; k < len - 2; k++) begin
				crc = crc16_byte(crc, body[k], cur_poly);
			end
			body[len-2] = crc[7:0];
			body[len-1] = crc[15:8];
		end
		if (flaw == FLAW_HEADER && len > 0) begin
			k = (len > 1) ? $urandom_range(1) : 0;
			body[k] = body[k] ^ 8'($urandom_range(1, 255));
		end else if (flaw == FLAW_CRC && len > 1) begin
			k = len - 1 - $urandom_range(1);
			body[k] = body[k] ^ 8'($urandom_range(1, 255));
		end
		for (k = 0; k < len; k++) begin
			w.mode = (mixed && k != len - 1) ? 2'($urandom) : end_mode;
			w.in_byte = body[k];
			w.in_last = (k == len - 1);
			drive_word(w);
		end
	endtask

	initial begin
		int r;
		int pick;
		int want;
		int len;
		int ph;
		int k;
		int random_start;
		int phase_start;
		frame_flaw_t flaw;
		logic [1:0] m;
		in_word_t w;

		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: generate extremes, mode three, a one-byte check frame
		drive_word(in_word_t'{MODE_GEN, 8'h00, 1'b1});
		drive_word(in_word_t'{MODE_GEN_ALT, 8'hFF, 1'b0});
		drive_word(in_word_t'{MODE_GEN_ALT, 8'hFF, 1'b1});
		drive_word(in_word_t'{MODE_SEND, HDR_FIRST, 1'b1});
		wait_drained();

		configure(16'h8005, 16'h0000, 7'd4, 7'd1);
		send_frame(MODE_SEND, 4, FLAW_NONE, 1'b0);
		send_frame(MODE_SEND, 4, FLAW_HEADER, 1'b0);
		send_frame(MODE_SEND, 4, FLAW_CRC, 1'b0);
		send_frame(MODE_RECV, 1, FLAW_NONE, 1'b0);
		send_frame(MODE_SEND, 4, FLAW_NONE, 1'b1);
		wait_drained();

		// two-byte frame: empty CRC equals the seed, matched by the header bytes
		configure(16'hFFFF, {HDR_SECOND, HDR_FIRST}, 7'd2, 7'd3);
		send_frame(MODE_SEND, 2, FLAW_NONE, 1'b0);
		send_frame(MODE_RECV, 3, FLAW_NONE, 1'b0);

		random_start = words_sent;
		ph = 0;
		while (words_sent - random_start < RANDOM_WORDS) begin
			wait_drained();
			case (ph % 6)
				0: configure(POLY_RESET, INIT_RESET, SEND_LEN_RESET, RECV_LEN_RESET);
				1: configure(16'h0000, 16'h0000, 7'd4, 7'd4);
				2: configure(16'hFFFF, 16'hFFFF, 7'd64, 7'd5);
				3: configure(16'($urandom), 16'($urandom), 7'($urandom_range(4, 12)),
						7'($urandom_range(4, 12)));
				4: configure(16'($urandom), 16'($urandom), 7'd127, 7'($urandom_range(4, 8)));
				default: configure(16'($urandom), 16'($urandom), 7'($urandom_range(4, 10)),
						7'd64);
			endcase
			no_gaps = (ph % 6 == 3);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS &&
					words_sent - random_start < RANDOM_WORDS) begin
				r = $urandom_range(99);
				if (r < 76) begin
					m = (r < 38) ? MODE_SEND : MODE_RECV;
					want = (m == MODE_SEND) ? cur_send : cur_recv;
					pick = $urandom_range(99);
					if (pick < 62) begin
						flaw = FLAW_NONE;
					end else if (pick < 76) begin
						flaw = FLAW_HEADER;
					end else if (pick < 90) begin
						flaw = FLAW_CRC;
					end else begin
						flaw = FLAW_LENGTH;
					end
					if (want >= 4 && want <= MAX_FRAME_BYTES) begin
						len = want;
					end else begin
						len = $urandom_range(4, 10);
					end
					if (flaw == FLAW_LENGTH) begin
						len = $urandom_range(1, 12);
						if (len == want) begin
							len = want + 1;
						end
					end
					if ($urandom_range(29) == 0) begin
						len = 70;
					end
					send_frame(m, len, flaw, $urandom_range(3) == 0);
				end else if (r < 92) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
					send_frame($urandom_range(1) ? MODE_GEN_ALT : MODE_GEN, len, FLAW_NONE,
							$urandom_range(3) == 0);
				end else begin
					len = $urandom_range(1, 6);
					for (k = 0; k < len; k++) begin
						w.mode = 2'($urandom);
						w.in_byte = 8'($urandom);
						w.in_last = (k == len - 1);
						drive_word(w);
					end
				end
				// hold off the sender until the output side has caught up
				if ($urandom_range(19) == 0) begin
					wait_drained();
				end
			end
			ph++;
		end
		no_gaps = 1'b0;

		wait_drained();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
